// ===== hdl/psi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psi_pkg: shared definitions for the pointer segment intern block
// Field widths, parameter defaults and the sequencer state type.
// ----------------------------------------------------------------------------
package psi_pkg;

  localparam int PSI_PTR_W     = 64;
  localparam int PSI_COMPACT_W = 47;
  localparam int PSI_INDEX_W   = 8;

  localparam int PSI_SEG_BITS  = 8;
  localparam int PSI_LOW_BITS  = 39;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } psi_state_e;

endpackage

// ===== hdl/psi_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psi_if: item channels of the pointer segment intern block
// Input channel carries one pointer, output channel one interned result.
// ----------------------------------------------------------------------------
interface psi_in_if
  import psi_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [PSI_PTR_W-1:0] pointer_in;

  modport source (output valid, output pointer_in, input ready);
  modport sink   (input valid, input pointer_in, output ready);
endinterface

interface psi_out_if
  import psi_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [PSI_COMPACT_W-1:0] compact_value;
  logic [PSI_INDEX_W-1:0]   segment_index;
  logic                     new_entry;
  logic                     table_full;

  modport source (output valid, output compact_value, output segment_index,
                  output new_entry, output table_full, input ready);
  modport sink   (input valid, input compact_value, input segment_index,
                  input new_entry, input table_full, output ready);
endinterface

// ===== hdl/pointer_segment_intern.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointer_segment_intern: map 64-bit pointers to compact segment form
// Linear tag search over a small table with append on miss.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  (valid/ready) takes one pointer per item. The bits from LOW_BITS
//         up are the tag, the bits below are the offset.
//   out_o (valid/ready) gives one result per item: compact_value,
//         segment_index, new_entry and table_full.
// The tag table has one write and one registered read port: while the
// scan runs a read is issued each cycle and the registered data is
// compared on the next. ready is high only while the sequencer is idle,
// so one item is in work at a time.
// A finished result sits in the output register; the next item is already
// taken while it waits. If the receiver stalls and that register is still
// full when the next result is done, the sequencer holds it until it frees.
// Reset empties the table logically (empty flag set, last index zero); the
// tag memory itself is not cleared since only written entries are read.
// The topmost index is reserved; an append that would reach it returns
// table_full with all other fields zero and leaves the table unchanged.
// ----------------------------------------------------------------------------
module pointer_segment_intern
  import psi_pkg::*;
#(
  parameter int SEG_BITS = PSI_SEG_BITS,
  parameter int LOW_BITS = PSI_LOW_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  psi_in_if.sink    in_i,
  psi_out_if.source out_o
);

  localparam int DEPTH = (1 << SEG_BITS) - 1;
  localparam int TAG_W = (PSI_PTR_W - LOW_BITS > 32) ? 32 : PSI_PTR_W - LOW_BITS;
  localparam logic [SEG_BITS-1:0]  RESERVED = '1;
  localparam logic [PSI_PTR_W-1:0] OFF_MASK =
    (PSI_PTR_W'(1) << LOW_BITS) - PSI_PTR_W'(1);

  psi_state_e state_q, state_d;

  logic [PSI_PTR_W-1:0] ptr_q, ptr_d;
  logic [SEG_BITS-1:0]  last_q, last_d;
  logic                 empty_q, empty_d;
  logic [SEG_BITS-1:0]  addr_q, addr_d;     // next read address
  logic [SEG_BITS-1:0]  cmp_idx_q, cmp_idx_d; // index of data in rdata_q
  logic                 cmp_vld_q, cmp_vld_d;

  // tag memory, one write and one registered read port
  logic [TAG_W-1:0]    tag_mem [DEPTH];
  logic [TAG_W-1:0]    rdata_q;
  logic                rd_en;
  logic                mem_we;
  logic [SEG_BITS-1:0] mem_waddr;

  // output register
  logic                     out_vld_q;
  logic [PSI_COMPACT_W-1:0] compact_q;
  logic [PSI_INDEX_W-1:0]   index_q;
  logic                     new_q;
  logic                     full_q;

  // result being finished this cycle
  logic                 finish;
  logic [SEG_BITS-1:0]  res_idx;
  logic                 res_new;
  logic                 res_full;
  logic                 slot_free;

  logic [TAG_W-1:0]     tag;
  logic [SEG_BITS-1:0]  next_idx;
  logic [PSI_PTR_W-1:0] idx_wide;
  logic [PSI_PTR_W-1:0] compact_wide;

  assign tag       = ptr_q[LOW_BITS +: TAG_W];
  assign next_idx  = last_q + SEG_BITS'(1);
  assign slot_free = !out_vld_q || out_o.ready;

  assign in_i.ready = (state_q == ST_IDLE);

  // sequencer
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    last_d    = last_q;
    empty_d   = empty_q;
    addr_d    = addr_q;
    cmp_idx_d = cmp_idx_q;
    cmp_vld_d = cmp_vld_q;
    rd_en     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = next_idx;
    finish    = 1'b0;
    res_idx   = '0;
    res_new   = 1'b0;
    res_full  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          ptr_d     = in_i.pointer_in;
          addr_d    = '0;
          cmp_vld_d = 1'b0;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (empty_q) begin
          // first tag goes to index zero
          if (slot_free) begin
            finish    = 1'b1;
            res_new   = 1'b1;
            mem_we    = 1'b1;
            mem_waddr = '0;
            last_d    = '0;
            empty_d   = 1'b0;
            state_d   = ST_IDLE;
          end
        end else if (cmp_vld_q && rdata_q == tag) begin
          if (slot_free) begin
            finish  = 1'b1;
            res_idx = cmp_idx_q;
            state_d = ST_IDLE;
          end
        end else if (cmp_vld_q && cmp_idx_q == last_q) begin
          // every stored tag checked: append or report full
          if (slot_free) begin
            finish  = 1'b1;
            state_d = ST_IDLE;
            if (next_idx == RESERVED) begin
              res_full = 1'b1;
            end else begin
              res_idx = next_idx;
              res_new = 1'b1;
              mem_we  = 1'b1;
              last_d  = next_idx;
            end
          end
        end else begin
          rd_en     = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = addr_q;
          addr_d    = addr_q + SEG_BITS'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign idx_wide     = PSI_PTR_W'(res_idx);
  assign compact_wide = (idx_wide << LOW_BITS) | (ptr_q & OFF_MASK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      last_q    <= '0;
      empty_q   <= 1'b1;
      addr_q    <= '0;
      cmp_idx_q <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      last_q    <= last_d;
      empty_q   <= empty_d;
      addr_q    <= addr_d;
      cmp_idx_q <= cmp_idx_d;
      cmp_vld_q <= cmp_vld_d;
      if (finish) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (finish) begin
      if (res_full) begin
        compact_q <= '0;
        index_q   <= '0;
      end else begin
        compact_q <= compact_wide[PSI_COMPACT_W-1:0];
        index_q   <= idx_wide[PSI_INDEX_W-1:0];
      end
      new_q  <= res_new;
      full_q <= res_full;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[mem_waddr] <= tag;
    end
    if (rd_en) begin
      rdata_q <= tag_mem[addr_q];
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.compact_value = compact_q;
  assign out_o.segment_index = index_q;
  assign out_o.new_entry     = new_q;
  assign out_o.table_full    = full_q;

  // the reserved index is never taken
  a_last_below_reserved: assert property (
    @(posedge clk_i) disable iff (!rst_ni) last_q != RESERVED)
    else $error("last index reached the reserved index");

  // the scan never compares beyond the last used index
  a_scan_in_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && cmp_vld_q) |-> (cmp_idx_q <= last_q))
    else $error("scan compared past the last used index");

  // a full result only ever comes from a table at its limit
  a_full_at_limit: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && full_q) |-> (last_q == RESERVED - SEG_BITS'(1) && !new_q))
    else $error("table full reported below the limit");

  // once a tag is appended the table is no longer empty
  a_append_clears_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (finish && res_new) |=> !empty_q)
    else $error("append left the table marked empty");

  // a finished result never overwrites one still waiting
  a_no_overwrite: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    finish |-> (!out_vld_q || out_o.ready))
    else $error("result overwrote a pending item");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: pointer_segment_intern self-checking bench
// Drives 64-bit pointers through the valid/ready input channel and checks
// every interned result against an in-bench model of the tag table. Runs
// directed extremes first, then random pointers that mix fresh tags and
// reused ones until the table fills up and table-full results appear.
// ----------------------------------------------------------------------------
module testbench;
  import psi_pkg::*;

  localparam int TAG_W       = PSI_PTR_W - PSI_LOW_BITS;  // 25 bits at default
  localparam int SEG_COUNT   = (1 << PSI_SEG_BITS) - 1;   // last index reserved
  localparam int RANDOM_ITEMS = 838;
  localparam int HOLD_OFF_AT  = 400;  // receiver holds off after this many items
  localparam int HOLD_OFF_CYC = 600;
  localparam int DRAIN_AT     = 450;  // sender waits for all results here
  localparam int TAIL_CYC     = 300;  // longer than one full-table scan

  typedef struct packed {
    logic [PSI_COMPACT_W-1:0] compact_value;
    logic [PSI_INDEX_W-1:0]   segment_index;
    logic                     new_entry;
    logic                     table_full;
  } intern_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tag table model plus the queue of results still owed
  // --------------------------------------------------------------------------
  class intern_scoreboard;
    bit [TAG_W-1:0] seg_tags [SEG_COUNT];
    int unsigned    last_idx;
    bit             empty;
    intern_result_t pending_results [$];
    int unsigned    error_count;
    int unsigned    checked_count;
    int unsigned    hit_count;
    int unsigned    append_count;
    int unsigned    full_count;
    int unsigned    deepest_hit;

    function new();
      empty       = 1'b1;
      last_idx    = 0;
      error_count = 0;
      checked_count = 0;
      hit_count   = 0;
      append_count = 0;
      full_count  = 0;
      deepest_hit = 0;
    endfunction

    // Look up or append the tag, return the compact form of the pointer
    function intern_result_t intern_pointer(bit [PSI_PTR_W-1:0] ptr);
      intern_result_t           res;
      bit [TAG_W-1:0]           tag;
      bit [PSI_LOW_BITS-1:0]    offset;
      bit [63:0]                packed_val;
      int unsigned              idx;
      int unsigned              i;
      bit                       found;
      tag    = ptr[PSI_PTR_W-1:PSI_LOW_BITS];
      offset = ptr[PSI_LOW_BITS-1:0];
      res    = '0;
      found  = 1'b0;
      idx    = 0;
      if (empty) begin
        // very first tag lands at index 0
        empty       = 1'b0;
        last_idx    = 0;
        seg_tags[0] = tag;
        res.new_entry = 1'b1;
        found       = 1'b1;
        append_count++;
      end else begin
        for (i = 0; i <= last_idx; i++) begin
          if (!found && seg_tags[i] == tag) begin
            idx   = i;
            found = 1'b1;
          end
        end
        if (found) begin
          hit_count++;
          if (idx > deepest_hit) deepest_hit = idx;
        end
      end
      if (!found) begin
        if (last_idx + 1 >= SEG_COUNT) begin
          // no room: everything zero except the flag, table untouched
          res.table_full = 1'b1;
          full_count++;
          return res;
        end
        last_idx++;
        seg_tags[last_idx] = tag;
        idx = last_idx;
        res.new_entry = 1'b1;
        append_count++;
      end
      packed_val        = (64'(idx) << PSI_LOW_BITS) | 64'(offset);
      res.compact_value = packed_val[PSI_COMPACT_W-1:0];
      res.segment_index = idx[PSI_INDEX_W-1:0];
      return res;
    endfunction

    function void note_pointer(bit [PSI_PTR_W-1:0] ptr);
      pending_results.push_back(intern_pointer(ptr));
    endfunction

    function void check_result(intern_result_t got);
      intern_result_t exp;
      if (pending_results.size() == 0) begin
        $error("unexpected result: compact_value %h with nothing pending",
               got.compact_value);
        error_count++;
        return;
      end
      exp = pending_results.pop_front();
      checked_count++;
      if (got.compact_value !== exp.compact_value) begin
        $error("compact_value: expected %h, actual %h", exp.compact_value,
               got.compact_value);
        error_count++;
      end
      if (got.segment_index !== exp.segment_index) begin
        $error("segment_index: expected %0d, actual %0d", exp.segment_index,
               got.segment_index);
        error_count++;
      end
      if (got.new_entry !== exp.new_entry) begin
        $error("new_entry: expected %b, actual %b", exp.new_entry, got.new_entry);
        error_count++;
      end
      if (got.table_full !== exp.table_full) begin
        $error("table_full: expected %b, actual %b", exp.table_full,
               got.table_full);
        error_count++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, block
  // --------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;

  psi_in_if  in_ch ();
  psi_out_if out_ch ();

  pointer_segment_intern dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  intern_scoreboard sb = new();

  bit [TAG_W-1:0] issued_tags [$];   // every tag offered so far, for reuse
  int unsigned    accepted_items;
  bit             held_off;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Extremes of the pointer: all zeros / all ones, tag-only and offset-only
  // patterns, a pointer reused with a different offset, top tag bit alone.
  bit [PSI_PTR_W-1:0] directed_ptrs [12] = '{
    64'h0000_0000_0000_0000,   // empty table: first tag at index 0
    64'hFFFF_FFFF_FFFF_FFFF,   // max tag, max offset
    64'hFFFF_FF80_0000_0000,   // same max tag, zero offset -> hit
    64'h0000_007F_FFFF_FFFF,   // zero tag, max offset -> hit at index 0
    64'h0000_0080_0000_0000,   // lowest tag bit only
    64'h8000_0000_0000_0000,   // highest tag bit only
    64'h0000_007F_FFFF_FFFF,
    64'h5555_5555_5555_5555,
    64'hAAAA_AAAA_AAAA_AAAA,
    64'h5555_5500_0000_0000,   // tag of the 5555 pointer, offset cleared
    64'h0000_0100_0000_0000,
    64'hFFFF_FFFF_FFFF_FFFF
  };

  // --------------------------------------------------------------------------
  // Sender side. Called at a falling edge; returns at the falling edge after
  // the item was taken. keep_valid leaves valid up for the next item of a
  // burst so it is never dropped and raised in the same step.
  // --------------------------------------------------------------------------
  task automatic offer_pointer(input bit [PSI_PTR_W-1:0] ptr, input bit keep_valid);
    in_ch.valid      <= 1'b1;
    in_ch.pointer_in <= ptr;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    sb.note_pointer(ptr);
    accepted_items++;
    @(negedge clk_i);
    if (!keep_valid) in_ch.valid <= 1'b0;
  endtask

  task automatic wait_all_results();
    while (sb.pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Mostly reuses known tags so hits land at every depth; about 40% fresh
  // tags fill the table partway through and then run into table-full.
  function automatic bit [PSI_PTR_W-1:0] make_pointer();
    bit [TAG_W-1:0]        tag;
    bit [63:0]             raw;
    bit [PSI_LOW_BITS-1:0] offset;
    int unsigned           pick;
    pick = $urandom_range(0, 99);
    if (issued_tags.size() == 0 || pick < 40) begin
      tag = TAG_W'($urandom);
      issued_tags.push_back(tag);
    end else begin
      tag = issued_tags[$urandom_range(0, issued_tags.size() - 1)];
    end
    raw    = {$urandom, $urandom};
    offset = raw[PSI_LOW_BITS-1:0];
    pick   = $urandom_range(0, 9);
    if (pick == 0) offset = '0;
    else if (pick == 1) offset = '1;
    return {tag, offset};
  endfunction

  // --------------------------------------------------------------------------
  // Receiver side: ready steps through a 16-bit pattern that is redrawn
  // with a new random mode (sometimes always ready). One long hold-off once
  // enough items are in, so the output register fills and the input stalls.
  // --------------------------------------------------------------------------
  initial begin
    bit [15:0]   pattern;
    int unsigned phase;
    int unsigned mode;
    out_ch.ready = 1'b0;
    held_off     = 1'b0;
    phase        = 0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      case (mode)
        0: begin
          pattern = 16'hFFFF;
        end
        1: begin
          pattern = 16'h0101;
        end
        default: begin
          pattern = 16'($urandom) | 16'h0001;
        end
      endcase
      repeat (128) begin
        @(negedge clk_i);
        if (!held_off && accepted_items >= HOLD_OFF_AT) begin
          held_off     = 1'b1;
          out_ch.ready <= 1'b0;
          repeat (HOLD_OFF_CYC) @(negedge clk_i);
        end
        out_ch.ready <= pattern[phase % 16];
        phase++;
      end
    end
  end

  // Monitor: sample at the rising edge, before the block updates
  always @(posedge clk_i) begin
    intern_result_t got;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.compact_value = out_ch.compact_value;
      got.segment_index = out_ch.segment_index;
      got.new_entry     = out_ch.new_entry;
      got.table_full    = out_ch.table_full;
      sb.check_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned sent;
    int unsigned burst_len;
    int unsigned b;
    bit          paused;
    in_ch.valid      = 1'b0;
    in_ch.pointer_in = '0;
    accepted_items   = 0;
    rst_ni           = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed items back to back, no sender gaps
    foreach (directed_ptrs[k]) begin
      issued_tags.push_back(directed_ptrs[k][PSI_PTR_W-1:PSI_LOW_BITS]);
      offer_pointer(directed_ptrs[k], k != 11);
    end
    wait_all_results();

    // random bursts; a long burst now and then gives stretches with no gaps
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(1, 12);
      for (b = 0; b < burst_len && sent < RANDOM_ITEMS; b++) begin
        offer_pointer(make_pointer(), (b + 1 < burst_len) && (sent + 1 < RANDOM_ITEMS));
        sent++;
      end
      if (!paused && sent >= DRAIN_AT) begin
        paused = 1'b1;
        wait_all_results();
      end
      repeat ($urandom_range(1, 20)) @(negedge clk_i);
    end

    wait_all_results();
    repeat (TAIL_CYC) @(negedge clk_i);

    $display("run: %0d pointers in, %0d results checked", accepted_items,
             sb.checked_count);
    $display("run: %0d appends, %0d hits (deepest index %0d), %0d table-full",
             sb.append_count, sb.hit_count, sb.deepest_hit, sb.full_count);
    if (sb.error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Hang guard: well beyond the slowest legal run
  initial begin
    #25_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/psi_pkg.sv
hdl/psi_if.sv
hdl/pointer_segment_intern.sv
tb/sv/testbench.sv
